[src/jtl_pkg.sv]
// Shared types, token codes and character helpers for the JSON token lexer.
package jtl_pkg;

  localparam int unsigned OffsetBits = 16;
  localparam int unsigned KindBits   = 4;
  localparam int unsigned QueueDepth = 4;

  localparam logic [KindBits-1:0] KIND_OBJ_START = 4'd0;
  localparam logic [KindBits-1:0] KIND_OBJ_END   = 4'd1;
  localparam logic [KindBits-1:0] KIND_ARR_START = 4'd2;
  localparam logic [KindBits-1:0] KIND_ARR_END   = 4'd3;
  localparam logic [KindBits-1:0] KIND_COLON     = 4'd4;
  localparam logic [KindBits-1:0] KIND_COMMA     = 4'd5;
  localparam logic [KindBits-1:0] KIND_STRING    = 4'd6;
  localparam logic [KindBits-1:0] KIND_NUMBER    = 4'd7;
  localparam logic [KindBits-1:0] KIND_LITERAL   = 4'd8;
  localparam logic [KindBits-1:0] KIND_EOF       = 4'd9;
  localparam logic [KindBits-1:0] KIND_ERROR     = 4'd10;

  localparam logic [1:0] LIT_NULL  = 2'd0;
  localparam logic [1:0] LIT_TRUE  = 2'd1;
  localparam logic [1:0] LIT_FALSE = 2'd2;

  typedef struct packed {
    logic [KindBits-1:0]   kind;
    logic [OffsetBits-1:0] tok_begin;
    logic [OffsetBits-1:0] tok_end;
    logic                  last;
  } token_t;

  function automatic token_t mk_token(logic [KindBits-1:0] kind,
                                      logic [OffsetBits-1:0] b,
                                      logic [OffsetBits-1:0] e,
                                      logic last);
    token_t t;
    t.kind      = kind;
    t.tok_begin = b;
    t.tok_end   = e;
    t.last      = last;
    return t;
  endfunction

  function automatic logic is_num_char(logic [7:0] c);
    return (c >= "0" && c <= "9") || c == "." || c == "e" || c == "E" ||
           c == "+" || c == "-";
  endfunction

  // Expected byte of literal w at position p.
  function automatic logic [7:0] lit_char(logic [1:0] w, logic [2:0] p);
    logic [7:0] ch;
    unique case ({w, p})
      {LIT_NULL, 3'd0}:  ch = "n";
      {LIT_NULL, 3'd1}:  ch = "u";
      {LIT_NULL, 3'd2}:  ch = "l";
      {LIT_NULL, 3'd3}:  ch = "l";
      {LIT_TRUE, 3'd0}:  ch = "t";
      {LIT_TRUE, 3'd1}:  ch = "r";
      {LIT_TRUE, 3'd2}:  ch = "u";
      {LIT_TRUE, 3'd3}:  ch = "e";
      {LIT_FALSE, 3'd0}: ch = "f";
      {LIT_FALSE, 3'd1}: ch = "a";
      {LIT_FALSE, 3'd2}: ch = "l";
      {LIT_FALSE, 3'd3}: ch = "s";
      {LIT_FALSE, 3'd4}: ch = "e";
      default:           ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [2:0] lit_len(logic [1:0] w);
    return (w == LIT_FALSE) ? 3'd5 : 3'd4;
  endfunction

endpackage

[src/json_token_lexer_unit.sv]
// JSON token lexer: byte stream in, token stream with offsets out.
//
// Takes one byte of JSON text per cycle while s_axis_tready_o is high (tlast
// marks the final byte) and produces tokens with begin and exclusive end
// offsets. A byte is held in an input register and resolved combinationally
// into a registered four-entry result queue that drives the output; each
// byte can give up to three tokens (a closed number, the token the byte
// itself starts, and eof), and the queue drains one token per cycle while
// the receiver is ready. A byte is taken every cycle as long as the queue,
// after this cycle's drain, has room for three tokens. Every text closes
// with exactly one eof or error token carrying tlast; after an error the
// rest of the text is consumed silently up to its final byte, and offsets
// restart at zero with the next text.
module json_token_lexer_unit
  import jtl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tlast_i,   // final_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [3:0] token_kind, [19:4] token_begin,
                                        // [35:20] token_end, [39:36] zero
  output logic        m_axis_tlast_o    // last_result
);

  // lexer modes
  localparam logic [2:0] MODE_IDLE = 3'd0;
  localparam logic [2:0] MODE_STR  = 3'd1;
  localparam logic [2:0] MODE_ESC  = 3'd2;
  localparam logic [2:0] MODE_NUM  = 3'd3;
  localparam logic [2:0] MODE_LIT  = 3'd4;

  localparam int unsigned CntBits = $clog2(QueueDepth + 1);

  // input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_fin_q;

  // lexer state
  logic [2:0]            mode_q, mode_d;
  logic [1:0]            which_q, which_d;
  logic [2:0]            lpos_q, lpos_d;
  logic [OffsetBits-1:0] ts_q, ts_d;
  logic [OffsetBits-1:0] off_q, off_d;
  logic                  err_q, err_d;

  // results of the current byte
  token_t     res [4];
  logic [1:0] res_cnt;

  // result queue, head at entry 0
  token_t             q_q [QueueDepth];
  token_t             q_d [QueueDepth];
  logic [CntBits-1:0] cnt_q, cnt_d;

  logic               pop;
  logic [CntBits-1:0] base;
  logic               fire;

  assign pop  = m_axis_tvalid_o && m_axis_tready_i;
  assign base = cnt_q - CntBits'(pop);
  // three free slots needed before a byte is resolved
  assign fire = in_valid_q && (base <= CntBits'(QueueDepth - 3));

  assign s_axis_tready_o = !in_valid_q || fire;

  // ---------------------------------------------------------------------
  // Per-byte lexer step
  // ---------------------------------------------------------------------
  always_comb begin
    logic [7:0]            c;
    logic [OffsetBits-1:0] pos;
    logic [OffsetBits-1:0] nxt;
    logic                  take;
    logic [1:0]            lw;
    logic [2:0]            lp;

    c    = in_byte_q;
    pos  = off_q;
    nxt  = pos + 1'b1;
    take = 1'b1;
    lw   = (which_q == 2'd3) ? LIT_NULL : which_q;
    lp   = (lpos_q > 3'd4) ? 3'd4 : lpos_q;

    mode_d  = mode_q;
    which_d = which_q;
    lpos_d  = lpos_q;
    ts_d    = ts_q;
    off_d   = off_q;
    err_d   = err_q;
    res_cnt = 2'd0;
    for (int i = 0; i < 4; i++) res[i] = '0;

    if (err_q) begin
      // drain the rest of a failed text
      take = 1'b0;
    end else if (pos == '1) begin
      // offset limit reached
      res[res_cnt] = mk_token(KIND_ERROR, pos, pos, 1'b1);
      res_cnt      = res_cnt + 2'd1;
      err_d        = 1'b1;
      take         = 1'b0;
    end else begin
      unique case (mode_q)
        MODE_STR: begin
          if (c == "\\") begin
            mode_d = MODE_ESC;
          end else if (c == "\"") begin
            res[res_cnt] = mk_token(KIND_STRING, ts_q, nxt, 1'b0);
            res_cnt      = res_cnt + 2'd1;
            mode_d       = MODE_IDLE;
          end
          take = 1'b0;
        end
        MODE_ESC: begin
          mode_d = MODE_STR;
          take   = 1'b0;
        end
        MODE_LIT: begin
          if (c == lit_char(lw, lp)) begin
            lpos_d = lp + 3'd1;
            if (lpos_d >= lit_len(lw)) begin
              res[res_cnt] = mk_token(KIND_LITERAL, ts_q, nxt, 1'b0);
              res_cnt      = res_cnt + 2'd1;
              mode_d       = MODE_IDLE;
            end
          end else begin
            res[res_cnt] = mk_token(KIND_ERROR, ts_q + 1'b1, ts_q + 1'b1, 1'b1);
            res_cnt      = res_cnt + 2'd1;
            err_d        = 1'b1;
          end
          take = 1'b0;
        end
        MODE_NUM: begin
          if (is_num_char(c)) begin
            take = 1'b0;
          end else begin
            res[res_cnt] = mk_token(KIND_NUMBER, ts_q, pos, 1'b0);
            res_cnt      = res_cnt + 2'd1;
            mode_d       = MODE_IDLE;
          end
        end
        default: mode_d = MODE_IDLE;
      endcase

      if (take) begin
        unique case (c) inside
          " ", 8'h09, 8'h0a, 8'h0d: ;
          "{": begin
            res[res_cnt] = mk_token(KIND_OBJ_START, pos, nxt, 1'b0);
            res_cnt      = res_cnt + 2'd1;
          end
          "}": begin
            res[res_cnt] = mk_token(KIND_OBJ_END, pos, nxt, 1'b0);
            res_cnt      = res_cnt + 2'd1;
          end
          "[": begin
            res[res_cnt] = mk_token(KIND_ARR_START, pos, nxt, 1'b0);
            res_cnt      = res_cnt + 2'd1;
          end
          "]": begin
            res[res_cnt] = mk_token(KIND_ARR_END, pos, nxt, 1'b0);
            res_cnt      = res_cnt + 2'd1;
          end
          ":": begin
            res[res_cnt] = mk_token(KIND_COLON, pos, nxt, 1'b0);
            res_cnt      = res_cnt + 2'd1;
          end
          ",": begin
            res[res_cnt] = mk_token(KIND_COMMA, pos, nxt, 1'b0);
            res_cnt      = res_cnt + 2'd1;
          end
          "\"": begin
            mode_d = MODE_STR;
            ts_d   = pos;
          end
          "n", "t", "f": begin
            mode_d  = MODE_LIT;
            which_d = (c == "n") ? LIT_NULL : ((c == "t") ? LIT_TRUE : LIT_FALSE);
            lpos_d  = 3'd1;
            ts_d    = pos;
          end
          default: begin
            if ((c >= "0" && c <= "9") || c == "+" || c == "-") begin
              mode_d = MODE_NUM;
              ts_d   = pos;
            end else if (!in_fin_q) begin
              res[res_cnt] = mk_token(KIND_ERROR, nxt, nxt, 1'b1);
              res_cnt      = res_cnt + 2'd1;
              err_d        = 1'b1;
            end
          end
        endcase
      end

      off_d = nxt;

      // end of text: flush a pending number or flag an open string, then eof if no error
      if (in_fin_q) begin
        if (mode_d == MODE_NUM) begin
          res[res_cnt] = mk_token(KIND_NUMBER, ts_d, nxt, 1'b0);
          res_cnt      = res_cnt + 2'd1;
        end else if ((mode_d == MODE_STR || mode_d == MODE_ESC) &&
                     (ts_d + 1'b1 != nxt)) begin
          res[res_cnt] = mk_token(KIND_ERROR, ts_d + 1'b1, ts_d + 1'b1, 1'b1);
          res_cnt      = res_cnt + 2'd1;
          err_d        = 1'b1;
        end
        if (!err_d) begin
          res[res_cnt] = mk_token(KIND_EOF, nxt, nxt, 1'b1);
          res_cnt      = res_cnt + 2'd1;
        end
      end
    end

    // every text starts from a clean state
    if (in_fin_q) begin
      mode_d  = MODE_IDLE;
      which_d = LIT_NULL;
      lpos_d  = 3'd0;
      ts_d    = '0;
      off_d   = '0;
      err_d   = 1'b0;
    end
  end

  // ---------------------------------------------------------------------
  // Result queue: shift out at the head, append at the tail
  // ---------------------------------------------------------------------
  always_comb begin
    logic [CntBits-1:0] idx;
    idx = '0;
    for (int i = 0; i < QueueDepth; i++) begin
      if (pop && i < QueueDepth - 1) q_d[i] = q_q[i + 1];
      else                           q_d[i] = q_q[i];
      idx = CntBits'(i) - base;
      if (fire && CntBits'(i) >= base && idx < CntBits'(res_cnt)) begin
        q_d[i] = res[idx[1:0]];
      end
    end
    cnt_d = base + (fire ? CntBits'(res_cnt) : '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      mode_q     <= MODE_IDLE;
      which_q    <= LIT_NULL;
      lpos_q     <= 3'd0;
      ts_q       <= '0;
      off_q      <= '0;
      err_q      <= 1'b0;
      cnt_q      <= '0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (fire) begin
        mode_q  <= mode_d;
        which_q <= which_d;
        lpos_q  <= lpos_d;
        ts_q    <= ts_d;
        off_q   <= off_d;
        err_q   <= err_d;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_byte_q <= s_axis_tdata_i;
      in_fin_q  <= s_axis_tlast_i;
    end
    for (int i = 0; i < QueueDepth; i++) q_q[i] <= q_d[i];
  end

  assign m_axis_tvalid_o = (cnt_q != '0);
  assign m_axis_tdata_o  = {4'b0000, q_q[0].tok_end, q_q[0].tok_begin, q_q[0].kind};
  assign m_axis_tlast_o  = q_q[0].last;

endmodule

[src/jtl_checker.sv]
// Port-level assertions for the JSON token lexer, bound to the top level.
module jtl_checker
  import jtl_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [7:0]  s_axis_tdata_i,
  input logic        s_axis_tlast_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [39:0] m_axis_tdata_o,
  input logic        m_axis_tlast_o
);

  logic [KindBits-1:0] kind;
  assign kind = m_axis_tdata_o[KindBits-1:0];

  // input transaction holds until taken
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && !s_axis_tready_o |=>
      s_axis_tvalid_i && $stable(s_axis_tdata_i) && $stable(s_axis_tlast_i))
    else $error("input transaction changed while stalled");

  // output transaction holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output transaction changed while stalled");

  // tlast marks exactly the closing eof or error token
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tlast_o == (kind == KIND_EOF || kind == KIND_ERROR)))
    else $error("tlast does not match token kind");

  // closing tokens carry a single offset
  a_close_offsets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |->
      m_axis_tdata_o[19:4] == m_axis_tdata_o[35:20])
    else $error("eof or error with differing offsets");

  // ordinary tokens cover at least one byte and are not eof or error kinds
  a_token_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tlast_o |->
      m_axis_tdata_o[35:20] > m_axis_tdata_o[19:4] && kind <= KIND_LITERAL)
    else $error("token with empty span or bad kind");

endmodule

bind json_token_lexer_unit jtl_checker u_jtl_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .s_axis_tlast_i  (s_axis_tlast_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

[tb/lexer_sb_pkg.sv]
// Token scoreboard with a byte-level predictor for the JSON token lexer bench.
package lexer_sb_pkg;
  import jtl_pkg::*;

  typedef enum logic [2:0] {
    SCAN_IDLE,
    SCAN_STRING,
    SCAN_ESCAPE,
    SCAN_NUMBER,
    SCAN_LITERAL
  } scan_mode_e;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // A byte at this offset can no longer be given an end offset.
  localparam int unsigned OffsetLimit = (1 << OffsetBits) - 1;

  class token_scoreboard;
    token_t      expected_tokens[$];
    int unsigned failures;
    int unsigned live_bytes;   // bytes the lexer acts on (not swallowed after an error)

    scan_mode_e  mode;
    logic [1:0]  lit_sel;
    int unsigned lit_idx;
    int unsigned tok_start;
    int unsigned offset;
    bit          halted;
    string       words[3];

    function new();
      words[LIT_NULL]  = "null";
      words[LIT_TRUE]  = "true";
      words[LIT_FALSE] = "false";
      failures   = 0;
      live_bytes = 0;
      clear_scan();
    endfunction

    function void clear_scan();
      mode      = SCAN_IDLE;
      lit_sel   = LIT_NULL;
      lit_idx   = 0;
      tok_start = 0;
      offset    = 0;
      halted    = 1'b0;
    endfunction

    function bit continues_number(logic [7:0] c);
      return (c >= "0" && c <= "9") || c == "." || c == "e" || c == "E" ||
             c == "+" || c == "-";
    endfunction

    function void expect_token(logic [KindBits-1:0] kind, int unsigned b, int unsigned e,
                               logic last);
      token_t t;
      t.kind      = kind;
      t.tok_begin = b[OffsetBits-1:0];
      t.tok_end   = e[OffsetBits-1:0];
      t.last      = last;
      expected_tokens.push_back(t);
    endfunction

    // Work out the tokens that one accepted byte gives.
    function void note_byte(logic [7:0] c, logic fin);
      int unsigned pos;
      bit          opens;
      string       w;
      if (halted) begin
        if (fin) clear_scan();
        return;
      end
      live_bytes++;
      pos = offset;
      if (pos >= OffsetLimit) begin
        // pending token is dropped
        expect_token(KIND_ERROR, pos, pos, 1'b1);
        halted = 1'b1;
        if (fin) clear_scan();
        return;
      end

      opens = 1'b1;
      case (mode)
        SCAN_STRING: begin
          if (c == "\\") mode = SCAN_ESCAPE;
          else if (c == "\"") begin
            expect_token(KIND_STRING, tok_start, pos + 1, 1'b0);
            mode = SCAN_IDLE;
          end
          opens = 1'b0;
        end
        SCAN_ESCAPE: begin
          mode  = SCAN_STRING;
          opens = 1'b0;
        end
        SCAN_LITERAL: begin
          w = words[lit_sel];
          if (c == w[lit_idx]) begin
            lit_idx++;
            if (lit_idx >= w.len()) begin
              expect_token(KIND_LITERAL, tok_start, pos + 1, 1'b0);
              mode = SCAN_IDLE;
            end
          end else begin
            expect_token(KIND_ERROR, tok_start + 1, tok_start + 1, 1'b1);
            halted = 1'b1;
          end
          opens = 1'b0;
        end
        SCAN_NUMBER: begin
          if (continues_number(c)) opens = 1'b0;
          else begin
            // the closing byte goes on to start its own token
            expect_token(KIND_NUMBER, tok_start, pos, 1'b0);
            mode = SCAN_IDLE;
          end
        end
        default: mode = SCAN_IDLE;
      endcase

      if (opens) begin
        case (c)
          CH_SPACE, CH_TAB, CH_LF, CH_CR: ;
          "{": expect_token(KIND_OBJ_START, pos, pos + 1, 1'b0);
          "}": expect_token(KIND_OBJ_END, pos, pos + 1, 1'b0);
          "[": expect_token(KIND_ARR_START, pos, pos + 1, 1'b0);
          "]": expect_token(KIND_ARR_END, pos, pos + 1, 1'b0);
          ":": expect_token(KIND_COLON, pos, pos + 1, 1'b0);
          ",": expect_token(KIND_COMMA, pos, pos + 1, 1'b0);
          "\"": begin
            mode      = SCAN_STRING;
            tok_start = pos;
          end
          "n", "t", "f": begin
            mode      = SCAN_LITERAL;
            lit_sel   = (c == "n") ? LIT_NULL : ((c == "t") ? LIT_TRUE : LIT_FALSE);
            lit_idx   = 1;
            tok_start = pos;
          end
          default: begin
            if ((c >= "0" && c <= "9") || c == "+" || c == "-") begin
              mode      = SCAN_NUMBER;
              tok_start = pos;
            end else if (!fin) begin
              expect_token(KIND_ERROR, pos + 1, pos + 1, 1'b1);
              halted = 1'b1;
            end
          end
        endcase
      end

      offset = pos + 1;

      if (fin) begin
        if (!halted) begin
          if (mode == SCAN_NUMBER) begin
            expect_token(KIND_NUMBER, tok_start, offset, 1'b0);
          end else if ((mode == SCAN_STRING || mode == SCAN_ESCAPE) &&
                       tok_start + 1 != offset) begin
            expect_token(KIND_ERROR, tok_start + 1, tok_start + 1, 1'b1);
            halted = 1'b1;
          end
          if (!halted) expect_token(KIND_EOF, offset, offset, 1'b1);
        end
        clear_scan();
      end
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        failures++;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    // Compare one output transaction with the oldest expected token.
    function void check_token(logic [39:0] data, logic last);
      token_t want;
      if (expected_tokens.size() == 0) begin
        failures++;
        $display("%0t: unexpected token: expected none, actual kind %0d begin %0d",
                 $time, data[3:0], data[19:4]);
        $display("%0t:   end %0d last %0d", $time, data[35:20], last);
        return;
      end
      want = expected_tokens.pop_front();
      compare_field("token_kind", want.kind, data[3:0]);
      compare_field("token_begin", want.tok_begin, data[19:4]);
      compare_field("token_end", want.tok_end, data[35:20]);
      compare_field("tdata pad", 0, data[39:36]);
      compare_field("last_result", want.last, last);
    endfunction

    function int unsigned pending();
      return expected_tokens.size();
    endfunction
  endclass

endpackage

[tb/tb_top.sv]
// Testbench top: feeds JSON texts to the lexer and checks every token it returns.
module tb_top;
  import jtl_pkg::*;
  import lexer_sb_pkg::*;

  localparam int unsigned CycleLimit  = 100_000;
  localparam int unsigned HoldCycles  = 300;        // receiver back-pressure stretch
  localparam int unsigned PhaseBytes  = 100;        // live bytes per random phase
  localparam int unsigned DrainCycles = 20;

  logic        clk      = 1'b0;
  logic        rst_n    = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'h00;
  logic        s_tlast  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tlast;

  int unsigned src_idle_pct  = 0;
  int unsigned sink_idle_pct = 0;
  int unsigned hold_asks     = 0;   // bumped by the main process
  int unsigned hold_done     = 0;   // owned by the receiver
  int unsigned hold_left     = 0;
  int unsigned cycles        = 0;

  token_scoreboard sb;
  logic [7:0]      text_q[$];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  json_token_lexer_unit DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast)
  );

  // Receiver: random ready, or a long hold-off when one is requested. The
  // hold is counted here so the sender keeps offering bytes meanwhile and
  // the result queue fills up and throttles s_tready.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (hold_done != hold_asks) begin
      hold_done <= hold_asks;
      hold_left <= HoldCycles;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Output monitor. Sampling at the falling edge sees settled values that
  // the next rising edge will use, so there is no race with the lexer's flops.
  always @(negedge clk) begin
    if (rst_n && m_tvalid && m_tready) sb.check_token(m_tdata, m_tlast);
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("%0t: timeout after %0d cycles, %0d tokens outstanding",
               $time, cycles, sb.pending());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // One input transaction. Called at a rising edge; returns at the rising
  // edge where the byte was taken.
  task automatic push_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= fin;
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    sb.note_byte(b, fin);
    @(posedge clk);
  endtask

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) push_byte(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  function automatic void add_word(string w);
    for (int i = 0; i < w.len(); i++) text_q.push_back(w[i]);
  endfunction

  function automatic void add_blanks();
    int unsigned n;
    n = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
    repeat (n) begin
      case ($urandom_range(3))
        0:       text_q.push_back(CH_SPACE);
        1:       text_q.push_back(CH_TAB);
        2:       text_q.push_back(CH_LF);
        default: text_q.push_back(CH_CR);
      endcase
    end
  endfunction

  // String with arbitrary content bytes and the odd escape.
  function automatic void add_string();
    logic [7:0] c;
    text_q.push_back("\"");
    repeat ($urandom_range(0, 5)) begin
      if ($urandom_range(5) == 0) begin
        text_q.push_back("\\");
        text_q.push_back(8'($urandom_range(255)));
      end else begin
        c = 8'($urandom_range(255));
        if (c == "\"" || c == "\\") c = "a";
        text_q.push_back(c);
      end
    end
    text_q.push_back("\"");
  endfunction

  function automatic void add_number();
    string lead;
    string tail;
    lead = "0123456789+-";
    tail = "0123456789.eE+-";
    text_q.push_back(lead[$urandom_range(11)]);
    repeat ($urandom_range(0, 4)) text_q.push_back(tail[$urandom_range(14)]);
  endfunction

  // Well-formed JSON value; containers only near the top to keep texts short.
  function automatic void add_value(int unsigned depth);
    int unsigned pick;
    int unsigned n;
    pick = (depth < 2) ? $urandom_range(5) : $urandom_range(2);
    case (pick)
      0: add_string();
      1: add_number();
      2: begin
        case ($urandom_range(2))
          0:       add_word("null");
          1:       add_word("true");
          default: add_word("false");
        endcase
      end
      3: begin
        text_q.push_back("{");
        add_blanks();
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
          if (i > 0) begin
            text_q.push_back(",");
            add_blanks();
          end
          add_string();
          add_blanks();
          text_q.push_back(":");
          add_blanks();
          add_value(depth + 1);
          add_blanks();
        end
        text_q.push_back("}");
      end
      default: begin
        text_q.push_back("[");
        add_blanks();
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
          if (i > 0) begin
            text_q.push_back(",");
            add_blanks();
          end
          add_value(depth + 1);
          add_blanks();
        end
        text_q.push_back("]");
      end
    endcase
  endfunction

  // Mostly intact texts; the rest cut short (unterminated strings, truncated
  // literals, pending numbers), with one corrupted byte, or pure noise.
  // Several values back to back let a number be closed by any token start.
  function automatic void make_random_text();
    int unsigned shape;
    int unsigned cut;
    shape = $urandom_range(99);
    if (shape < 10) begin
      repeat ($urandom_range(1, 8)) text_q.push_back(8'($urandom_range(255)));
    end else begin
      add_blanks();
      repeat ($urandom_range(1, 3)) begin
        add_value(0);
        add_blanks();
      end
      if (shape < 30) begin
        cut = $urandom_range(1, text_q.size());
        while (text_q.size() > cut) void'(text_q.pop_back());
      end else if (shape < 45) begin
        text_q[$urandom_range(text_q.size() - 1)] = 8'($urandom_range(255));
      end
    end
  endfunction

  // Short hand-made texts: every token kind, each way a text can end early,
  // bad start bytes in and at the end of a text, bytes swallowed after an error.
  task automatic run_directed();
    add_word("{\"\\\"\":-5}");   // escaped quote in string, number closed by brace
    send_text();
    add_word("[true,nul");       // truncated literal gives eof
    send_text();
    add_word("false]0");         // number still open at the final byte
    send_text();
    add_word("fx");              // literal mismatch, then a swallowed final byte
    text_q.push_back(8'hFF);
    send_text();
    text_q.push_back(8'h00);     // bad start byte mid-text
    add_word("7");
    send_text();
    add_word("\"\\");            // trailing backslash, string left open
    send_text();
    add_word("\"");              // lone quote as the final byte gives eof, not an error
    send_text();
    text_q.push_back(8'hFF);     // bad start byte as the final byte
    send_text();
  endtask

  initial begin
    int unsigned first;
    bit          asked;
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    src_idle_pct  = 31;
    sink_idle_pct = 51;
    run_directed();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct  = 31;
          sink_idle_pct = 51;
        end
        1: begin
          src_idle_pct  = 51;
          sink_idle_pct = 31;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
      endcase

      first = sb.live_bytes;
      asked = 1'b0;
      while (sb.live_bytes - first < PhaseBytes) begin
        if (phase != 1 && !asked && sb.live_bytes - first > PhaseBytes / 3) begin
          hold_asks <= hold_asks + 1;
          asked = 1'b1;
        end
        make_random_text();
        send_text();
      end

      // sender pauses until every expected token is out
      s_tvalid <= 1'b0;
      do @(posedge clk); while (sb.pending() != 0);
    end

    repeat (DrainCycles) @(posedge clk);
    if (sb.failures == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
